[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/core/pcsf_pkg.sv]
// Package with the shared types and constants of the point cloud sphere flip block.
`default_nettype none
package pcsf_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;

	typedef enum logic [1:0] {
		KIND_ORIGIN = 2'd0,
		KIND_POINT  = 2'd1,
		KIND_FILL   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_RADIUS  = 2'd0,
		REG_QUERY_X = 2'd1,
		REG_QUERY_Y = 2'd2,
		REG_QUERY_Z = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic       origin;
		logic       last;
		logic [5:0] fill;
	} ctrl_t;

endpackage
`default_nettype wire

[rtl/core/pcsf_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband.
`default_nettype none
module pcsf_isqrt import pcsf_pkg::*; #(
	parameter int RW     = 66,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [RW-1:0]     rad,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [RW/2-1:0]        root,
	output logic [SIDE_W-1:0]      out_side
);
	localparam int SQ = RW / 2;

	logic [SQ+1:0]     rem_s  [SQ];
	logic [SQ-1:0]     root_s [SQ];
	logic [RW-1:0]     rad_s  [SQ];
	logic [SIDE_W-1:0] side_s [SQ];
	logic [SQ-1:0]     v_s;

	for (genvar k = 0; k < SQ; k++) begin : g_stage
		logic [SQ+1:0]     rem_in;
		logic [SQ-1:0]     root_in;
		logic [RW-1:0]     rad_in;
		logic [SIDE_W-1:0] side_in;
		logic              v_in;
		logic [SQ+4:0]     cat;
		logic [SQ+4:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign cat   = {1'b0, rem_in, rad_in[RW-1:RW-2]};
		assign trial = cat - {3'b000, root_in, 2'b01};
		assign ge    = !trial[SQ+4];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? trial[SQ+1:0] : cat[SQ+1:0];
				root_s[k] <= {root_in[SQ-2:0], ge};
				rad_s[k]  <= {rad_in[RW-3:0], 2'b00};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = v_s[SQ-1];
	assign root      = root_s[SQ-1];
	assign out_side  = side_s[SQ-1];

endmodule
`default_nettype wire

[rtl/core/pcsf_div.sv]
// Pipelined three-lane restoring divider with overflow flag and sideband.
`default_nettype none
module pcsf_div import pcsf_pkg::*; #(
	parameter int W      = 32,
	parameter int SIDE_W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [2:0][2*W:0]    num,
	input  wire logic [W:0]           den,
	input  wire logic [SIDE_W-1:0]    in_side,
	output logic                      out_valid,
	output logic [2:0][W-1:0]         quo,
	output logic [2:0]                ovf,
	output logic [SIDE_W-1:0]         out_side
);
	localparam int PW = 2 * W + 1;

	logic [2:0][PW-1:0] rem_s  [W+1];
	logic [2:0][W-1:0]  q_s    [W+1];
	logic [2:0]         ovf_s  [W+1];
	logic [W:0]         den_s  [W+1];
	logic [SIDE_W-1:0]  side_s [W+1];
	logic [W:0]         v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ovf_s[0][a] <= num[a] >= (PW'(den) << W);
			end
			rem_s[0]  <= num;
			q_s[0]    <= '0;
			den_s[0]  <= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [PW-1:0] dsh;
		assign dsh = PW'(den_s[k-1]) << (W - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < 3; a++) begin
					if (rem_s[k-1][a] >= dsh) begin
						rem_s[k][a] <= rem_s[k-1][a] - dsh;
						q_s[k][a]   <= {q_s[k-1][a][W-2:0], 1'b1};
					end else begin
						rem_s[k][a] <= rem_s[k-1][a];
						q_s[k][a]   <= {q_s[k-1][a][W-2:0], 1'b0};
					end
				end
				ovf_s[k]  <= ovf_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[W];
	assign quo       = q_s[W];
	assign ovf       = ovf_s[W];
	assign out_side  = side_s[W];

endmodule
`default_nettype wire

[rtl/core/point_cloud_sphere_flip_top.sv]
// Top level of the point cloud sphere flip block.
// Input channel s_*: one cloud point per item, s_tlast marks the last point of a cloud.
// Output channel m_*: flipped points relative to the query point; m_tuser gives the
// kind (leading origin, flipped point, axis fill point) and m_tlast the final item.
// Configuration: cfg_we writes cfg_data into the register that cfg_index selects
// (radius, query x, y, z); write only while the block is idle.
// The first point of a cloud yields an origin item and its flipped point; the last
// point adds one fill item for each axis side that no point reached.
// The square root and divider pipelines produce one result bit per stage.
// A point enters every cycle while each point yields one item and the receiver keeps up;
// items that yield several results hold the input until their last result is emitted.
// Reset clears all valid bits and the open-stream flag and sets all side flags; the
// configuration returns to radius 1.0 and a query point at the origin.
// When the receiver stalls, the whole pipeline holds and nothing is lost.
`default_nettype none
module point_cloud_sphere_flip_top import pcsf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	localparam int IN_DW  = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [COORD_WIDTH-1:0] cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_DW-1:0]       s_tdata,  // point_x, point_y, point_z
	input  wire logic                   s_tlast,  // last_point
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_DW-1:0]           m_tdata,  // out_x, out_y, out_z
	output logic [1:0]                  m_tuser,  // out_kind
	output logic                        m_tlast   // last_out
);
	localparam int W     = COORD_WIDTH;
	localparam int PS    = (W > 32) ? (W - 32) : 0;
	localparam int SW    = W - PS;
	localparam int RW    = 2 * SW + 2;
	localparam int SQ    = RW / 2;
	localparam int PW    = 2 * W + 1;
	localparam int CW    = $bits(ctrl_t);
	localparam int TENTH = ((2 ** FRAC_BITS) + 5) / 10;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W+1:0] TENTH_X = (W+2)'(TENTH);

	logic [W-2:0]        radius_q;
	logic signed [W-1:0] qry_q [3];
	logic [5:0]          flags_q;
	logic                open_q;
	logic                adv;

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= (W-1)'(2 ** FRAC_BITS);
			qry_q[0] <= '0;
			qry_q[1] <= '0;
			qry_q[2] <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RADIUS:  radius_q <= cfg_data[W-2:0];
				REG_QUERY_X: qry_q[0] <= cfg_data;
				REG_QUERY_Y: qry_q[1] <= cfg_data;
				REG_QUERY_Z: qry_q[2] <= cfg_data;
				default:     radius_q <= radius_q;
			endcase
		end
	end

	// Stage 1: relative coordinates and side flags.
	logic signed [W:0]   diff [3];
	logic [5:0]          flags_nx;
	logic signed [W-1:0] rel_s1 [3];
	ctrl_t               ctrl_s1;
	logic                v_s1;
	logic                take;

	assign s_tready = adv;
	assign take     = s_tvalid && adv;

	always_comb begin
		flags_nx = flags_q;
		for (int a = 0; a < 3; a++) begin
			diff[a] = {s_tdata[a*W+W-1], s_tdata[a*W +: W]} - {qry_q[a][W-1], qry_q[a]};
			if (!diff[a][W] && diff[a] != '0) flags_nx[2*a] = 1'b0;
			if (diff[a][W]) flags_nx[2*a+1] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '1;
			open_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			if (s_tvalid) begin
				flags_q <= s_tlast ? 6'h3f : flags_nx;
				open_q  <= !s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int a = 0; a < 3; a++) begin
				if (diff[a][W] != diff[a][W-1]) begin
					rel_s1[a] <= diff[a][W] ? CMIN : CMAX;
				end else begin
					rel_s1[a] <= diff[a][W-1:0];
				end
			end
			ctrl_s1.origin <= !open_q;
			ctrl_s1.last   <= s_tlast;
			ctrl_s1.fill   <= s_tlast ? flags_nx : 6'h00;
		end
	end

	// Stage 2: squares of the magnitudes.
	logic [W-1:0]        mag1 [3];
	logic [2*SW-1:0]     sq_s2 [3];
	logic signed [W-1:0] rel_s2 [3];
	ctrl_t               ctrl_s2;
	logic                v_s2;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag1[a] = rel_s1[a][W-1] ? W'(-rel_s1[a]) : W'(rel_s1[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= mag1[a][W-1:PS] * mag1[a][W-1:PS];
			end
			rel_s2  <= rel_s1;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// Stage 3: sum of squares.
	logic [RW-1:0]       sum_s3;
	logic signed [W-1:0] rel_s3 [3];
	ctrl_t               ctrl_s3;
	logic                v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= RW'(sq_s2[0]) + RW'(sq_s2[1]) + RW'(sq_s2[2]);
			rel_s3  <= rel_s2;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// Square root.
	logic [SQ-1:0]     root;
	logic [3*W+CW-1:0] sq_side;
	logic              sq_valid;

	pcsf_isqrt #(.RW(RW), .SIDE_W(3 * W + CW)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.rad       (sum_s3),
		.in_side   ({ctrl_s3, rel_s3[2], rel_s3[1], rel_s3[0]}),
		.out_valid (sq_valid),
		.root      (root),
		.out_side  (sq_side)
	);

	// Stage 4: norm, flip distance and signs.
	logic [W:0]            n4;
	logic signed [W+1:0]   m4;
	logic signed [W-1:0]   rel4 [3];
	logic [W:0]            n_s4;
	logic [W:0]            magm_s4;
	logic [W-1:0]          magc_s4 [3];
	logic [2:0]            neg_s4;
	ctrl_t                 ctrl_s4;
	logic                  v_s4;

	always_comb begin
		n4 = (W+1)'(root) << PS;
		m4 = $signed({2'b00, radius_q, 1'b0}) - $signed({1'b0, n4});
		for (int a = 0; a < 3; a++) begin
			rel4[a] = sq_side[a*W +: W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4    <= n4;
			magm_s4 <= m4[W+1] ? (W+1)'(-m4) : m4[W:0];
			for (int a = 0; a < 3; a++) begin
				magc_s4[a] <= rel4[a][W-1] ? W'(-rel4[a]) : W'(rel4[a]);
				neg_s4[a]  <= (rel4[a] != '0) && (m4 != '0) && (rel4[a][W-1] != m4[W+1]);
			end
			ctrl_s4 <= ctrl_t'(sq_side[3*W +: CW]);
		end
	end

	// Stage 5: products.
	logic [2:0][PW-1:0] prod_s5;
	logic [W:0]         n_s5;
	logic [2:0]         neg_s5;
	ctrl_t              ctrl_s5;
	logic               v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				prod_s5[a] <= PW'(magc_s4[a]) * PW'(magm_s4);
			end
			n_s5    <= n_s4;
			neg_s5  <= neg_s4;
			ctrl_s5 <= ctrl_s4;
		end
	end

	// Division.
	logic [2:0][W-1:0] quo;
	logic [2:0]        ovf;
	logic [CW+3:0]     dv_side;
	logic              dv_valid;
	logic              nz_d;
	logic [2:0]        neg_d;

	pcsf_div #(.W(W), .SIDE_W(CW + 4)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.num       (prod_s5),
		.den       (n_s5),
		.in_side   ({ctrl_s5, (n_s5 != '0), neg_s5}),
		.out_valid (dv_valid),
		.quo       (quo),
		.ovf       (ovf),
		.out_side  (dv_side)
	);

	assign neg_d = dv_side[2:0];
	assign nz_d  = dv_side[3];

	// Result holder and sequencer.
	logic signed [W-1:0] h_xyz_q [3];
	logic [7:0]          h_pend_q;
	logic                h_last_q;
	logic                h_valid_q;
	logic signed [W-1:0] fin [3];
	logic [7:0]          sel;
	logic [7:0]          rest;
	logic                ofree;
	logic                emit;
	logic signed [W+1:0] pos_x;
	logic signed [W+1:0] neg_x;
	logic signed [W-1:0] pos_v;
	logic signed [W-1:0] neg_v;
	logic signed [W-1:0] e_xyz [3];
	kind_t               e_kind;
	logic                o_valid_q;
	logic signed [W-1:0] o_xyz_q [3];
	kind_t               o_kind_q;
	logic                o_last_q;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (!nz_d) begin
				fin[a] = '0;
			end else if (ovf[a] || quo[a][W-1]) begin
				fin[a] = neg_d[a] ? CMIN : CMAX;
			end else begin
				fin[a] = neg_d[a] ? W'(-quo[a]) : quo[a];
			end
		end
	end

	assign pos_x = $signed({2'b00, radius_q, 1'b0}) - TENTH_X;
	assign neg_x = TENTH_X - $signed({2'b00, radius_q, 1'b0});
	assign pos_v = (pos_x > (W+2)'(CMAX)) ? CMAX : pos_x[W-1:0];
	assign neg_v = (neg_x < $signed((W+2)'(CMIN))) ? CMIN : neg_x[W-1:0];

	assign sel   = h_pend_q & (~h_pend_q + 8'd1);
	assign rest  = h_pend_q & ~sel;
	assign ofree = !o_valid_q || m_tready;
	assign emit  = h_valid_q && ofree;
	assign adv   = !h_valid_q || (emit && rest == '0);

	always_comb begin
		e_xyz[0] = '0;
		e_xyz[1] = '0;
		e_xyz[2] = '0;
		e_kind   = KIND_FILL;
		if (sel[0]) begin
			e_kind = KIND_ORIGIN;
		end else if (sel[1]) begin
			e_kind = KIND_POINT;
			e_xyz  = h_xyz_q;
		end
		for (int s = 0; s < 6; s++) begin
			if (sel[s+2]) e_xyz[s/2] = (s % 2 == 1) ? neg_v : pos_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_pend_q  <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				h_valid_q <= dv_valid;
				h_pend_q  <= {dv_side[4 +: 6], 1'b1, dv_side[CW+3]};
			end else if (emit) begin
				h_pend_q <= rest;
			end
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_xyz_q  <= fin;
			h_last_q <= dv_side[CW+2];
		end
		if (emit) begin
			o_xyz_q  <= e_xyz;
			o_kind_q <= e_kind;
			o_last_q <= h_last_q && (rest == '0);
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = OUT_DW'({o_xyz_q[2], o_xyz_q[1], o_xyz_q[0]});
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

endmodule
`default_nettype wire

[rtl/core/pcsf_checker.sv]
// Port-level checker for the point cloud sphere flip block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pcsf_checker import pcsf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	localparam int OUT_DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_DW-1:0] m_tdata,
	input wire logic [1:0]        m_tuser,
	input wire logic              m_tlast
);
	`ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_SAME(a_origin_zero, m_tvalid && m_tuser == KIND_ORIGIN, m_tdata == '0)
	`ASSERT_SAME(a_origin_not_last, m_tvalid && m_tuser == KIND_ORIGIN, !m_tlast)
	`ASSERT_NEXT(a_origin_then_point, m_tvalid && m_tready && m_tuser == KIND_ORIGIN,
		!m_tvalid || m_tuser == KIND_POINT)

endmodule

bind point_cloud_sphere_flip_top pcsf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pcsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

[tb/sv/point_cloud_sphere_flip_top_tb.sv]
// Testbench for the sphere flip block: a queue-fed driver, a checking monitor and a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module point_cloud_sphere_flip_top_tb;
	import pcsf_pkg::*;

	localparam longint CMAX = 64'sh7FFF_FFFF;
	localparam longint CMIN = -64'sh8000_0000;
	localparam longint TENTH = (65536 + 5) / 10;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [31:0] c [3];
		logic        last;
	} point_t;

	typedef struct {
		logic [31:0] x, y, z;
		kind_t       kind;
		logic        last;
	} flip_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	point_cloud_sphere_flip_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	point_t pending_points [$];
	flip_item_t flipped_q [$];
	point_t cur_point;
	int errors = 0;
	int send_idle = 13;
	int recv_idle = 74;
	int stall_left = 0;
	int cycles = 0;

	// Local copy of the block state and configuration.
	logic [30:0] radius_r = 31'd65536;
	longint query_r [3] = '{0, 0, 0};
	logic [5:0] empty_sides = 6'h3F;
	logic is_open = 1'b0;

	function automatic longint clip(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v) bits = bits >> 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] ray_scale(longint c, longint m, logic [63:0] n);
		logic [127:0] prod, quo;
		logic [63:0] mc, mm;
		mc = (c < 0) ? -c : c;
		mm = (m < 0) ? -m : m;
		prod = {64'd0, mc} * {64'd0, mm};
		quo = prod / {64'd0, n};
		if ((c < 0) != (m < 0) && c != 0 && m != 0) begin
			if (quo > 128'(CMAX)) return 32'h8000_0000;
			return -quo[31:0];
		end
		if (quo > 128'(CMAX)) return 32'h7FFF_FFFF;
		return quo[31:0];
	endfunction

	function automatic void push_flip(longint x, longint y, longint z, kind_t k);
		flip_item_t it;
		it.x = x[31:0];
		it.y = y[31:0];
		it.z = z[31:0];
		it.kind = k;
		it.last = 1'b0;
		flipped_q.insert(flipped_q.size(), it);
	endfunction

	function automatic void predict_flip(point_t p);
		longint d, m, posv, negv;
		longint rel [3];
		longint fv [3];
		logic [63:0] mg, sum, n;
		logic [31:0] out [3];
		sum = 0;
		if (!is_open) begin
			push_flip(0, 0, 0, KIND_ORIGIN);
			is_open = 1'b1;
		end
		for (int a = 0; a < 3; a++) begin
			d = longint'($signed(p.c[a])) - query_r[a];
			if (d > 0) empty_sides[2*a] = 1'b0;
			if (d < 0) empty_sides[2*a+1] = 1'b0;
			rel[a] = clip(d);
			mg = (rel[a] < 0) ? -rel[a] : rel[a];
			sum = sum + mg * mg;
		end
		n = int_root(sum);
		for (int a = 0; a < 3; a++) out[a] = '0;
		if (n != 0) begin
			m = 2 * longint'(radius_r) - longint'(n);
			for (int a = 0; a < 3; a++) out[a] = ray_scale(rel[a], m, n);
		end
		push_flip(longint'($signed(out[0])), longint'($signed(out[1])),
			longint'($signed(out[2])), KIND_POINT);
		if (p.last) begin
			posv = clip(2 * longint'(radius_r) - TENTH);
			negv = clip(TENTH - 2 * longint'(radius_r));
			for (int s = 0; s < 6; s++) begin
				if (empty_sides[s]) begin
					fv = '{0, 0, 0};
					fv[s >> 1] = (s & 1) ? negv : posv;
					push_flip(fv[0], fv[1], fv[2], KIND_FILL);
				end
			end
			flipped_q[$].last = 1'b1;
			empty_sides = 6'h3F;
			is_open = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_flip(cur_point);
			if (!s_tvalid || s_tready) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_point = pending_points.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_point.c[2], cur_point.c[1], cur_point.c[0]};
					s_tlast <= cur_point.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		flip_item_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("point_cloud_sphere_flip_top_tb failed");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (flipped_q.size() == 0) begin
					$display("unexpected item %h kind %0d", m_tdata, m_tuser);
					errors++;
				end else begin
					e = flipped_q.pop_front();
					if (m_tdata[31:0] !== e.x) report("out_x", m_tdata[31:0], e.x);
					if (m_tdata[63:32] !== e.y) report("out_y", m_tdata[63:32], e.y);
					if (m_tdata[95:64] !== e.z) report("out_z", m_tdata[95:64], e.z);
					if (m_tuser !== e.kind) report("out_kind", m_tuser, e.kind);
					if (m_tlast !== e.last) report("last_out", m_tlast, e.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RADIUS:  radius_r = val[30:0];
			REG_QUERY_X: query_r[0] = longint'($signed(val));
			REG_QUERY_Y: query_r[1] = longint'($signed(val));
			REG_QUERY_Z: query_r[2] = longint'($signed(val));
			default:     ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0 || s_tvalid || flipped_q.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic void add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic last);
		point_t p;
		p.c[0] = x;
		p.c[1] = y;
		p.c[2] = z;
		p.last = last;
		pending_points.insert(pending_points.size(), p);
	endfunction

	function automatic logic [31:0] rand_coord(int a);
		logic [31:0] q;
		q = query_r[a][31:0];
		case ($urandom_range(5))
			0, 1: return $urandom();
			2: return q + 32'($signed($urandom_range(2 * 262144) - 262144));
			3: return q;
			4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return q + 32'($signed($urandom_range(64) - 32));
		endcase
	endfunction

	task automatic random_clouds(int count);
		int len;
		while (count > 0) begin
			len = $urandom_range(12, 1);
			if (len > count) len = count;
			for (int i = 0; i < len; i++)
				add_point(rand_coord(0), rand_coord(1), rand_coord(2), i == len - 1);
			count -= len;
		end
	endtask

	task automatic random_config();
		case ($urandom_range(3))
			0: write_reg(REG_RADIUS, 32'h7FFF_FFFF);
			1: write_reg(REG_RADIUS, 32'd1);
			default: write_reg(REG_RADIUS, $urandom_range(1) ? $urandom() : $urandom_range(300000, 1));
		endcase
		write_reg(REG_QUERY_X, $urandom_range(1) ? $urandom() : $urandom_range(200000));
		write_reg(REG_QUERY_Y, $urandom_range(3) == 0 ? 32'h8000_0000 : $urandom());
		write_reg(REG_QUERY_Z, $urandom_range(3) == 0 ? 32'h7FFF_FFFF : $urandom());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_point(0, 0, 0, 1'b1);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'd65536, 0, 0, 1'b0);
		add_point(0, -32'sd65536, 0, 1'b0);
		add_point(0, 0, 32'd32768, 1'b0);
		add_point(32'd100, 32'd200, 32'd300, 1'b1);
		add_point(-32'sd1, 0, 0, 1'b1);
		add_point(0, 0, 32'd5, 1'b1);
		wait_drained();
		write_reg(REG_RADIUS, 32'hFFFF_FFFF);
		write_reg(REG_QUERY_X, 32'h8000_0000);
		write_reg(REG_QUERY_Y, 32'h7FFF_FFFF);
		write_reg(REG_QUERY_Z, 32'h0001_0000);
		@(negedge clk);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
		add_point(32'h0000_1234, 32'h7FFF_0000, 32'h0002_0000, 1'b1);
		wait_drained();
		write_reg(REG_RADIUS, 32'd0);
		write_reg(REG_QUERY_X, 0);
		write_reg(REG_QUERY_Y, 0);
		write_reg(REG_QUERY_Z, 0);
		@(negedge clk);
		add_point(32'd5, 32'd5, 32'd5, 1'b0);
		add_point(-32'sd70000, 32'd3, 0, 1'b1);
		wait_drained();
		write_reg(REG_RADIUS, 32'd1);
		@(negedge clk);
		add_point(32'd9, -32'sd9, 32'd9, 1'b1);
		wait_drained();
		stall_left = 400;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle = 74;
				recv_idle = 13;
			end else if (ph == 2) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int k = 0; k < 2; k++) begin
				random_config();
				@(negedge clk);
				random_clouds(75);
				wait_drained();
			end
		end
		if (errors == 0 && flipped_q.size() == 0) begin
			$display("point_cloud_sphere_flip_top_tb passed");
		end else begin
			$display("point_cloud_sphere_flip_top_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
